### sv/msi_vector_controller_assert.svh
// Assertion macros shared by the controller modules.
// Each expects clk and rst_n in the enclosing module.
`ifndef MSI_VECTOR_CONTROLLER_ASSERT_SVH
`define MSI_VECTOR_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define MSIVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSIVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/msivc_pkg.sv
package msivc_pkg;

  // Field widths
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned BLK_FIELD_W = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned VEC_W       = 16;

  // Controller geometry
  localparam int unsigned DEF_CTRL_COUNT   = 8;
  localparam int unsigned VECTORS_PER_CTRL = 32;
  localparam int unsigned VEC_SEL_W        = $clog2(VECTORS_PER_CTRL);
  localparam int unsigned VEC_BLK_W        = VEC_W - VEC_SEL_W;

  // Transaction type codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_MSI   = 2'd2
  } action_t;

  // Register select within a block
  typedef enum logic [KIND_W-1:0] {
    KIND_ENABLE = 2'd0,
    KIND_MASK   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Decoded operation on the register bank
  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_SET
  } op_t;

  // Decoder to bank request
  typedef struct packed {
    op_t                    op;
    kind_t                  kind;
    logic [BLK_FIELD_W-1:0] blk;
    logic [DATA_W-1:0]      data;
    logic                   claimed;
  } upd_t;

endpackage

### sv/msi_vector_controller.sv
// Channel  Dir  Handshake            Payload
// in_      in   in_valid / in_stall  action, ctrl_index, reg_kind, write_data,
//                                    msi_address, msi_vector
// out_     out  out_valid / out_stall read_data, msi_claimed, irq_out
// cfg_     in   cfg_wr_en            cfg_wr_data (MSI target address)
//
// One transaction per cycle sustained while out_stall is low; each passes the input
// register, then the result register, the block update being one read-modify-write.
// Synchronous active-low reset clears all enable, mask and status words and
// the target address.
// While out_stall holds a result, one more transaction is taken into the
// input register, then in_stall rises.
`include "msi_vector_controller_assert.svh"

module msi_vector_controller #(
  parameter int unsigned CTRL_COUNT = msivc_pkg::DEF_CTRL_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [msivc_pkg::ADDR_W-1:0]      cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [msivc_pkg::ACTION_W-1:0]    in_action,
  input  logic [msivc_pkg::BLK_FIELD_W-1:0] in_ctrl_index,
  input  logic [msivc_pkg::KIND_W-1:0]      in_reg_kind,
  input  logic [msivc_pkg::DATA_W-1:0]      in_write_data,
  input  logic [msivc_pkg::ADDR_W-1:0]      in_msi_address,
  input  logic [msivc_pkg::VEC_W-1:0]       in_msi_vector,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [msivc_pkg::DATA_W-1:0]      out_read_data,
  output logic                              out_msi_claimed,
  output logic                              out_irq_out
);

  logic [msivc_pkg::ADDR_W-1:0]      target_r;

  logic                              s1_valid_r, s1_valid_nxt;
  logic [msivc_pkg::ACTION_W-1:0]    s1_action_r;
  logic [msivc_pkg::BLK_FIELD_W-1:0] s1_ctrl_r;
  logic [msivc_pkg::KIND_W-1:0]      s1_kind_r;
  logic [msivc_pkg::DATA_W-1:0]      s1_wdata_r;
  logic [msivc_pkg::ADDR_W-1:0]      s1_addr_r;
  logic [msivc_pkg::VEC_W-1:0]       s1_vec_r;

  logic                              out_valid_r, out_valid_nxt;
  logic [msivc_pkg::DATA_W-1:0]      out_rdata_r;
  logic                              out_claimed_r;
  logic                              out_irq_r;

  logic                              adv;
  logic                              commit;
  msivc_pkg::upd_t                   upd;
  logic [msivc_pkg::DATA_W-1:0]      bank_rdata;
  logic                              bank_irq;

  // Flow control
  assign adv          = !out_valid_r || !out_stall;
  assign commit       = s1_valid_r && adv;
  assign in_stall     = s1_valid_r && !adv;
  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  // Target address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr_en) begin
      target_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action_r <= in_action;
      s1_ctrl_r   <= in_ctrl_index;
      s1_kind_r   <= in_reg_kind;
      s1_wdata_r  <= in_write_data;
      s1_addr_r   <= in_msi_address;
      s1_vec_r    <= in_msi_vector;
    end
  end

  msivc_decode #(
    .CTRL_COUNT (CTRL_COUNT)
  ) u_decode (
    .action      (s1_action_r),
    .ctrl_index  (s1_ctrl_r),
    .reg_kind    (s1_kind_r),
    .write_data  (s1_wdata_r),
    .msi_address (s1_addr_r),
    .msi_vector  (s1_vec_r),
    .target_addr (target_r),
    .upd         (upd)
  );

  msivc_bank #(
    .CTRL_COUNT (CTRL_COUNT)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .upd       (upd),
    .read_data (bank_rdata),
    .irq       (bank_irq)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_rdata_r   <= bank_rdata;
      out_claimed_r <= upd.claimed;
      out_irq_r     <= bank_irq;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_rdata_r;
  assign out_msi_claimed = out_claimed_r;
  assign out_irq_out     = out_irq_r;

  `MSIVC_ASSERT_NEXT(a_commit_shows, commit, out_valid_r, "committed transaction lost")
  `MSIVC_ASSERT_NOW(a_claim_rd, out_valid_r && out_claimed_r, out_rdata_r == '0, "bad read data")
  `MSIVC_ASSERT_NOW(a_stall_full, in_stall, s1_valid_r && out_valid_r, "stall with free space")

endmodule

### sv/msivc_decode.sv
module msivc_decode #(
  parameter int unsigned CTRL_COUNT = msivc_pkg::DEF_CTRL_COUNT
) (
  input  logic [msivc_pkg::ACTION_W-1:0]    action,
  input  logic [msivc_pkg::BLK_FIELD_W-1:0] ctrl_index,
  input  logic [msivc_pkg::KIND_W-1:0]      reg_kind,
  input  logic [msivc_pkg::DATA_W-1:0]      write_data,
  input  logic [msivc_pkg::ADDR_W-1:0]      msi_address,
  input  logic [msivc_pkg::VEC_W-1:0]       msi_vector,
  input  logic [msivc_pkg::ADDR_W-1:0]      target_addr,
  output msivc_pkg::upd_t                   upd
);

  localparam logic [msivc_pkg::BLK_FIELD_W:0] BLK_LIM =
    (msivc_pkg::BLK_FIELD_W + 1)'(CTRL_COUNT);
  localparam logic [msivc_pkg::VEC_BLK_W-1:0] VEC_BLK_LIM =
    msivc_pkg::VEC_BLK_W'(CTRL_COUNT);

  logic blk_ok;
  logic msi_hit;

  assign blk_ok  = ({1'b0, ctrl_index} < BLK_LIM);
  assign msi_hit = (msi_address == target_addr) &&
                   (msi_vector[msivc_pkg::VEC_W-1:msivc_pkg::VEC_SEL_W] < VEC_BLK_LIM);

  // Turn the transaction into one bank operation
  always_comb begin
    upd         = '0;
    upd.op      = msivc_pkg::OP_NONE;
    upd.kind    = msivc_pkg::kind_t'(reg_kind);
    unique case (msivc_pkg::action_t'(action))
      msivc_pkg::ACT_READ: begin
        if (blk_ok) begin
          upd.op  = msivc_pkg::OP_READ;
          upd.blk = ctrl_index;
        end
      end
      msivc_pkg::ACT_WRITE: begin
        if (blk_ok) begin
          upd.op   = msivc_pkg::OP_WRITE;
          upd.blk  = ctrl_index;
          upd.data = write_data;
        end
      end
      msivc_pkg::ACT_MSI: begin
        if (msi_hit) begin
          upd.op      = msivc_pkg::OP_SET;
          upd.claimed = 1'b1;
          upd.blk     = msi_vector[msivc_pkg::VEC_SEL_W +: msivc_pkg::BLK_FIELD_W];
          upd.data    = msivc_pkg::DATA_W'(1) << msi_vector[msivc_pkg::VEC_SEL_W-1:0];
        end
      end
      default: begin
        upd.op = msivc_pkg::OP_NONE;
      end
    endcase
  end

endmodule

### sv/msivc_bank.sv
`include "msi_vector_controller_assert.svh"

module msivc_bank #(
  parameter int unsigned CTRL_COUNT = msivc_pkg::DEF_CTRL_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         commit,
  input  msivc_pkg::upd_t              upd,
  output logic [msivc_pkg::DATA_W-1:0] read_data,
  output logic                         irq
);

  localparam int unsigned BLK_W = (CTRL_COUNT > 1) ? $clog2(CTRL_COUNT) : 1;

  logic [msivc_pkg::DATA_W-1:0] en_r   [CTRL_COUNT];
  logic [msivc_pkg::DATA_W-1:0] mask_r [CTRL_COUNT];
  logic [msivc_pkg::DATA_W-1:0] stat_r [CTRL_COUNT];
  logic [CTRL_COUNT-1:0]        pend_r;

  logic [BLK_W-1:0]             idx;
  logic                         touch;
  logic [msivc_pkg::DATA_W-1:0] cur_en, cur_mask, cur_stat;
  logic [msivc_pkg::DATA_W-1:0] new_en, new_mask, new_stat;
  logic                         new_pend;
  logic [CTRL_COUNT-1:0]        pend_after;
  logic [CTRL_COUNT-1:0]        pend_chk;

  assign idx      = upd.blk[BLK_W-1:0];
  assign touch    = (upd.op == msivc_pkg::OP_WRITE) || (upd.op == msivc_pkg::OP_SET);
  assign cur_en   = en_r[idx];
  assign cur_mask = mask_r[idx];
  assign cur_stat = stat_r[idx];

  // Read-modify-write of the addressed block
  always_comb begin
    new_en   = cur_en;
    new_mask = cur_mask;
    new_stat = cur_stat;
    if (upd.op == msivc_pkg::OP_WRITE) begin
      unique case (upd.kind)
        msivc_pkg::KIND_ENABLE: new_en   = upd.data;
        msivc_pkg::KIND_MASK:   new_mask = upd.data;
        msivc_pkg::KIND_STATUS: new_stat = cur_stat & ~upd.data;
        default:                new_en   = cur_en;
      endcase
    end else if (upd.op == msivc_pkg::OP_SET) begin
      new_stat = cur_stat | (upd.data & cur_en);
    end
  end

  assign new_pend = |(new_stat & ~new_mask);

  // Register read
  always_comb begin
    read_data = '0;
    if (upd.op == msivc_pkg::OP_READ) begin
      unique case (upd.kind)
        msivc_pkg::KIND_ENABLE: read_data = cur_en;
        msivc_pkg::KIND_MASK:   read_data = cur_mask;
        msivc_pkg::KIND_STATUS: read_data = cur_stat;
        default:                read_data = '0;
      endcase
    end
  end

  // Combined interrupt as it stands after this transaction
  always_comb begin
    for (int i = 0; i < CTRL_COUNT; i++) begin
      pend_after[i] = (touch && (BLK_W'(i) == idx)) ? new_pend : pend_r[i];
    end
  end

  assign irq = |pend_after;

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CTRL_COUNT; i++) begin
        en_r[i]   <= '0;
        mask_r[i] <= '0;
        stat_r[i] <= '0;
      end
      pend_r <= '0;
    end else if (commit && touch) begin
      en_r[idx]   <= new_en;
      mask_r[idx] <= new_mask;
      stat_r[idx] <= new_stat;
      pend_r[idx] <= new_pend;
    end
  end

  // Per-block pending recomputed from the words, for checking only
  always_comb begin
    for (int i = 0; i < CTRL_COUNT; i++) begin
      pend_chk[i] = |(stat_r[i] & ~mask_r[i]);
    end
  end

  `MSIVC_ASSERT_NOW(a_pend_match, 1'b1, pend_r == pend_chk, "pending bits out of sync")
  `MSIVC_ASSERT_NEXT(a_pend_hold, !commit, $stable(pend_r), "pending changed without commit")
  `MSIVC_ASSERT_NOW(a_rd_zero, upd.op != msivc_pkg::OP_READ, read_data == '0, "stray read data")

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CTRL_COUNT = msivc_pkg::DEF_CTRL_COUNT;
  localparam int unsigned VEC_COUNT  = CTRL_COUNT * msivc_pkg::VECTORS_PER_CTRL;
  // Codes that the package leaves unnamed
  localparam logic [msivc_pkg::ACTION_W-1:0] ACT_UNUSED  = 2'd3;
  localparam logic [msivc_pkg::KIND_W-1:0]   KIND_UNUSED = 2'd3;
  localparam logic [msivc_pkg::ADDR_W-1:0]   ADDR_ONES   = '1;

  // One input transaction
  typedef struct packed {
    logic [msivc_pkg::ACTION_W-1:0]    action;
    logic [msivc_pkg::BLK_FIELD_W-1:0] blk;
    logic [msivc_pkg::KIND_W-1:0]      kind;
    logic [msivc_pkg::DATA_W-1:0]      wdata;
    logic [msivc_pkg::ADDR_W-1:0]      addr;
    logic [msivc_pkg::VEC_W-1:0]       vec;
  } msi_txn_t;

  // One result transaction
  typedef struct packed {
    logic [msivc_pkg::DATA_W-1:0] read_data;
    logic                         claimed;
    logic                         irq;
  } msi_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic [msivc_pkg::ADDR_W-1:0]      cfg_wr_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [msivc_pkg::ACTION_W-1:0]    in_action = '0;
  logic [msivc_pkg::BLK_FIELD_W-1:0] in_ctrl_index = '0;
  logic [msivc_pkg::KIND_W-1:0]      in_reg_kind = '0;
  logic [msivc_pkg::DATA_W-1:0]      in_write_data = '0;
  logic [msivc_pkg::ADDR_W-1:0]      in_msi_address = '0;
  logic [msivc_pkg::VEC_W-1:0]       in_msi_vector = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [msivc_pkg::DATA_W-1:0]      out_read_data;
  logic                              out_msi_claimed;
  logic                              out_irq_out;

  // Shadow copy of the block's registers
  logic [msivc_pkg::ADDR_W-1:0] target_addr;
  logic [msivc_pkg::DATA_W-1:0] enable_word [CTRL_COUNT];
  logic [msivc_pkg::DATA_W-1:0] mask_word   [CTRL_COUNT];
  logic [msivc_pkg::DATA_W-1:0] status_word [CTRL_COUNT];

  msi_result_t pending_results [$];
  int unsigned mismatch_count = 0;
  bit          no_idle = 1'b0;

  msi_vector_controller #(.CTRL_COUNT(CTRL_COUNT)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_ctrl_index   (in_ctrl_index),
    .in_reg_kind     (in_reg_kind),
    .in_write_data   (in_write_data),
    .in_msi_address  (in_msi_address),
    .in_msi_vector   (in_msi_vector),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_msi_claimed (out_msi_claimed),
    .out_irq_out     (out_irq_out)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one transaction to the shadow registers, return the expected result
  function automatic msi_result_t vector_bank_update(input msi_txn_t t);
    msi_result_t r;
    logic [msivc_pkg::DATA_W-1:0] bit_sel;
    logic [msivc_pkg::BLK_FIELD_W-1:0] c;
    r = '0;
    if (t.action == msivc_pkg::ACT_READ && t.blk < CTRL_COUNT) begin
      case (t.kind)
        msivc_pkg::KIND_ENABLE: r.read_data = enable_word[t.blk];
        msivc_pkg::KIND_MASK:   r.read_data = mask_word[t.blk];
        msivc_pkg::KIND_STATUS: r.read_data = status_word[t.blk];
        default: ;
      endcase
    end else if (t.action == msivc_pkg::ACT_WRITE && t.blk < CTRL_COUNT) begin
      case (t.kind)
        msivc_pkg::KIND_ENABLE: enable_word[t.blk] = t.wdata;
        msivc_pkg::KIND_MASK:   mask_word[t.blk] = t.wdata;
        msivc_pkg::KIND_STATUS: status_word[t.blk] = status_word[t.blk] & ~t.wdata;
        default: ;
      endcase
    end else if (t.action == msivc_pkg::ACT_MSI) begin
      if (t.addr == target_addr && t.vec < VEC_COUNT) begin
        c = 3'(t.vec / msivc_pkg::VECTORS_PER_CTRL);
        bit_sel = 32'd1 << (t.vec % msivc_pkg::VECTORS_PER_CTRL);
        r.claimed = 1'b1;
        if ((enable_word[c] & bit_sel) != '0)
          status_word[c] = status_word[c] | bit_sel;
      end
    end
    // combined interrupt after the update
    for (int i = 0; i < CTRL_COUNT; i++) begin
      if ((status_word[i] & ~mask_word[i]) != '0)
        r.irq = 1'b1;
    end
    return r;
  endfunction

  // Transaction builders; unused fields get random filler
  function automatic msi_txn_t filler_txn();
    msi_txn_t t;
    t.action = ACT_UNUSED;
    t.blk    = 3'($urandom_range(0, 7));
    t.kind   = 2'($urandom_range(0, 3));
    t.wdata  = $urandom;
    t.addr   = {$urandom, $urandom};
    t.vec    = 16'($urandom);
    return t;
  endfunction

  function automatic msi_txn_t reg_txn(input logic [msivc_pkg::ACTION_W-1:0] act,
                                       input int unsigned blk,
                                       input logic [msivc_pkg::KIND_W-1:0] kind,
                                       input logic [msivc_pkg::DATA_W-1:0] data);
    msi_txn_t t;
    t = filler_txn();
    t.action = act;
    t.blk    = 3'(blk);
    t.kind   = kind;
    t.wdata  = data;
    return t;
  endfunction

  function automatic msi_txn_t msi_txn(input logic [msivc_pkg::ADDR_W-1:0] addr,
                                       input logic [msivc_pkg::VEC_W-1:0] vec);
    msi_txn_t t;
    t = filler_txn();
    t.action = msivc_pkg::ACT_MSI;
    t.addr   = addr;
    t.vec    = vec;
    return t;
  endfunction

  // Mostly claimed MSIs and register traffic, some misses and junk
  function automatic msi_txn_t random_txn();
    msi_txn_t t;
    int unsigned r;
    int unsigned sub;
    t = filler_txn();
    r = $urandom_range(0, 99);
    sub = $urandom_range(0, 19);
    if (r < 40) begin
      t.action = msivc_pkg::ACT_MSI;
      if (sub < 14) begin
        t.addr = target_addr;
        t.vec  = 16'($urandom_range(0, VEC_COUNT - 1));
      end else if (sub < 16) begin
        t.addr = target_addr;
      end else if (sub < 18) begin
        t.addr = target_addr ^ (64'd1 << $urandom_range(0, msivc_pkg::ADDR_W - 1));
        t.vec  = 16'($urandom_range(0, VEC_COUNT - 1));
      end
    end else if (r < 65) begin
      t.action = msivc_pkg::ACT_WRITE;
      if (sub < 8) begin
        t.kind  = msivc_pkg::KIND_ENABLE;
        t.wdata = $urandom | $urandom;
      end else if (sub < 13) begin
        t.kind = msivc_pkg::KIND_MASK;
      end else if (sub < 19) begin
        t.kind  = msivc_pkg::KIND_STATUS;
        t.wdata = $urandom & $urandom;
      end else begin
        t.kind = KIND_UNUSED;
      end
    end else if (r < 95) begin
      t.action = msivc_pkg::ACT_READ;
    end
    return t;
  endfunction

  // Send one transaction; the shadow is updated at the accepting edge
  task automatic send_txn(input msi_txn_t t);
    int unsigned gap;
    bit stalled;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= t.action;
    in_ctrl_index  <= t.blk;
    in_reg_kind    <= t.kind;
    in_write_data  <= t.wdata;
    in_msi_address <= t.addr;
    in_msi_vector  <= t.vec;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    pending_results.push_back(vector_bank_update(t));
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_target(input logic [msivc_pkg::ADDR_W-1:0] addr);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    target_addr = addr;
  endtask

  // Reset values: one enable, mask and status word each read zero, target address zero
  task automatic test_reset_values();
    send_txn(reg_txn(msivc_pkg::ACT_READ, 0, msivc_pkg::KIND_ENABLE, '0));
    send_txn(reg_txn(msivc_pkg::ACT_READ, 7, msivc_pkg::KIND_MASK, '0));
    send_txn(reg_txn(msivc_pkg::ACT_READ, 3, msivc_pkg::KIND_STATUS, '0));
    send_txn(msi_txn('0, 16'd5));
  endtask

  // Field extremes, every action and each corner of the MSI decode
  task automatic test_directed();
    write_target(ADDR_ONES);
    send_txn(reg_txn(msivc_pkg::ACT_WRITE, 7, msivc_pkg::KIND_ENABLE, 32'hffff_ffff));
    send_txn(reg_txn(msivc_pkg::ACT_WRITE, 0, msivc_pkg::KIND_ENABLE, 32'h0000_0001));
    send_txn(msi_txn(ADDR_ONES, 16'(VEC_COUNT - 1)));
    send_txn(msi_txn(ADDR_ONES, 16'(VEC_COUNT)));       // vector past the last block
    send_txn(msi_txn(ADDR_ONES, 16'hffff));
    send_txn(msi_txn(ADDR_ONES ^ 64'd1, 16'd0));        // address miss
    send_txn(msi_txn('0, 16'd0));
    send_txn(msi_txn(ADDR_ONES, 16'd1));                // disabled vector
    send_txn(msi_txn(ADDR_ONES, 16'd0));
    // masked pending bit
    send_txn(reg_txn(msivc_pkg::ACT_WRITE, 7, msivc_pkg::KIND_MASK, 32'h8000_0000));
    send_txn(reg_txn(msivc_pkg::ACT_WRITE, 0, msivc_pkg::KIND_STATUS, 32'h0000_0001));
    send_txn(msi_txn(ADDR_ONES, 16'((CTRL_COUNT - 1) * msivc_pkg::VECTORS_PER_CTRL)));
    send_txn(reg_txn(msivc_pkg::ACT_READ, 7, msivc_pkg::KIND_STATUS, '0));
    send_txn(reg_txn(msivc_pkg::ACT_READ, 7, msivc_pkg::KIND_MASK, '0));
    send_txn(reg_txn(msivc_pkg::ACT_READ, 7, msivc_pkg::KIND_ENABLE, '0));
    send_txn(reg_txn(msivc_pkg::ACT_WRITE, 7, msivc_pkg::KIND_STATUS, 32'h0));
    send_txn(reg_txn(msivc_pkg::ACT_WRITE, 7, msivc_pkg::KIND_STATUS, 32'hffff_ffff));
    send_txn(reg_txn(msivc_pkg::ACT_WRITE, 3, KIND_UNUSED, 32'hffff_ffff));
    send_txn(reg_txn(msivc_pkg::ACT_READ, 3, KIND_UNUSED, '0));
    send_txn(filler_txn());                             // unused action
    send_txn(reg_txn(msivc_pkg::ACT_WRITE, 7, msivc_pkg::KIND_MASK, 32'hffff_ffff));
    send_txn(reg_txn(msivc_pkg::ACT_READ, 7, msivc_pkg::KIND_STATUS, '0));
  endtask

  // Random traffic over several target addresses
  task automatic test_random();
    logic [msivc_pkg::ADDR_W-1:0] targets [6];
    targets[0] = '0;
    targets[1] = ADDR_ONES;
    targets[2] = {$urandom, $urandom};
    targets[3] = {32'h0, $urandom};
    targets[4] = {$urandom, $urandom};
    targets[5] = {$urandom, 32'hfee0_0000};
    for (int p = 0; p < 6; p++) begin
      write_target(targets[p]);
      for (int n = 0; n < 280; n++) begin
        if (n % 40 == 0)
          no_idle = ($urandom_range(0, 3) == 0);
        send_txn(random_txn());
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side back-pressure
  always begin : result_stall
    int unsigned hold;
    bit took;
    hold = no_idle ? 0 : $urandom_range(0, 6);
    if (hold > 0) begin
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
    out_stall <= 1'b0;
    do begin
      @(negedge clk);
      took = rst_n && out_valid;
      @(posedge clk);
    end while (!took);
  end

  // Compare each accepted result with the oldest expectation
  always @(negedge clk) begin : result_check
    msi_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_read_data !== exp_r.read_data) begin
          $error("read_data: expected %h, got %h", exp_r.read_data, out_read_data);
          mismatch_count++;
        end
        if (out_msi_claimed !== exp_r.claimed) begin
          $error("msi_claimed: expected %b, got %b", exp_r.claimed, out_msi_claimed);
          mismatch_count++;
        end
        if (out_irq_out !== exp_r.irq) begin
          $error("irq_out: expected %b, got %b", exp_r.irq, out_irq_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    target_addr = '0;
    for (int i = 0; i < CTRL_COUNT; i++) begin
      enable_word[i] = '0;
      mask_word[i]   = '0;
      status_word[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed();
    test_random();

    // wind down
    in_valid <= 1'b0;
    for (int w = 0; w < 5000 && pending_results.size() != 0; w++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("[msi_vector_controller] OK");
    else
      $display("[msi_vector_controller] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[msi_vector_controller] ERROR");
    $finish;
  end

endmodule
